### rtl/lcdnib_pkg.sv
`timescale 1ns / 1ps

package lcdnib_pkg;

	// Request kinds as they arrive on the request channel
	localparam logic [1:0] KIND_INIT = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_POS  = 2'd2;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Sequencer step counter
	localparam int          STEP_W    = 4;
	localparam logic [3:0]  INIT_LAST = 4'd13;

	// Waits in microseconds
	localparam int          WAIT_W        = 14;
	localparam logic [13:0] WAIT_NONE     = 14'd0;
	localparam logic [13:0] WAIT_POWER_UP = 14'd15000;
	localparam logic [13:0] WAIT_WAKE_ONE = 14'd5000;
	localparam logic [13:0] WAIT_WAKE_TWO = 14'd200;
	localparam logic [13:0] WAIT_CMD      = 14'd37;
	localparam logic [13:0] WAIT_DATA     = 14'd41;
	localparam logic [13:0] WAIT_CLEAR    = 14'd10000;

	// Instruction bytes used by the init run and position requests
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_ENTRY    = 8'h04;
	localparam logic [7:0] CMD_DISPLAY  = 8'h08;
	localparam logic [7:0] CMD_FUNCTION = 8'h20;
	localparam logic [7:0] CMD_DDRAM    = 8'h80;

	localparam logic [7:0] INIT_FUNC  = CMD_FUNCTION | 8'h08;
	localparam logic [7:0] INIT_OFF   = CMD_DISPLAY;
	localparam logic [7:0] INIT_ENTRY = CMD_ENTRY | 8'h02;
	localparam logic [7:0] INIT_ON    = CMD_DISPLAY | 8'h07;

	// Work item held in the queue
	typedef enum logic [1:0] {
		OP_INIT,
		OP_DATA,
		OP_ADDR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] code;
	} cmd_t;

	// One bus transfer
	typedef struct packed {
		logic [3:0]        nibble;
		logic              reg_select;
		logic [WAIT_W-1:0] pre_wait_us;
		logic [WAIT_W-1:0] post_wait_us;
		logic              last;
	} xfer_t;

	typedef struct packed {
		logic [3:0]        nibble;
		logic [WAIT_W-1:0] pre;
		logic [WAIT_W-1:0] post;
	} init_entry_t;

	// Init run: wake-up nibbles, then five bytes high nibble first
	function automatic init_entry_t init_xfer(logic [STEP_W-1:0] idx);
		init_entry_t e;
		e.pre  = WAIT_NONE;
		e.post = WAIT_NONE;
		case (idx)
			4'd0: begin
				e.nibble = 4'h3;
				e.pre    = WAIT_POWER_UP;
				e.post   = WAIT_WAKE_ONE;
			end
			4'd1: begin
				e.nibble = 4'h3;
				e.post   = WAIT_WAKE_TWO;
			end
			4'd2: begin
				e.nibble = 4'h3;
				e.post   = WAIT_CMD;
			end
			4'd3: begin
				e.nibble = 4'h2;
				e.post   = WAIT_CMD;
			end
			4'd4:  e.nibble = INIT_FUNC[7:4];
			4'd5: begin
				e.nibble = INIT_FUNC[3:0];
				e.post   = WAIT_CMD;
			end
			4'd6:  e.nibble = INIT_OFF[7:4];
			4'd7: begin
				e.nibble = INIT_OFF[3:0];
				e.post   = WAIT_CMD;
			end
			4'd8:  e.nibble = CMD_CLEAR[7:4];
			4'd9: begin
				e.nibble = CMD_CLEAR[3:0];
				e.post   = WAIT_CLEAR;
			end
			4'd10: e.nibble = INIT_ENTRY[7:4];
			4'd11: begin
				e.nibble = INIT_ENTRY[3:0];
				e.post   = WAIT_CMD;
			end
			4'd12: e.nibble = INIT_ON[7:4];
			4'd13: begin
				e.nibble = INIT_ON[3:0];
				e.post   = WAIT_CMD;
			end
			default: e.nibble = 4'h0;
		endcase
		return e;
	endfunction

endpackage

### rtl/lcdnib_if.sv
`timescale 1ns / 1ps

// Request channel
interface lcdnib_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_code;
	logic [5:0] column;
	logic       line;

	modport source (output valid, output kind, output char_code, output column,
		output line, input ready);
	modport sink (input valid, input kind, input char_code, input column,
		input line, output ready);
endinterface

// Bus transfer channel
interface lcdnib_xfer_if;
	logic        valid;
	logic        ready;
	logic [3:0]  nibble;
	logic        reg_select;
	logic [13:0] pre_wait_us;
	logic [13:0] post_wait_us;
	logic        last;

	modport source (output valid, output nibble, output reg_select,
		output pre_wait_us, output post_wait_us, output last, input ready);
	modport sink (input valid, input nibble, input reg_select,
		input pre_wait_us, input post_wait_us, input last, output ready);
endinterface

### rtl/lcdnib_front.sv
`timescale 1ns / 1ps

module lcdnib_front (
	lcdnib_req_if.sink        req,
	input  logic              full,
	output logic              push,
	output lcdnib_pkg::cmd_t  push_cmd
);

	logic known;

	// Take a request whenever the queue has room
	assign req.ready = !full;

	// Classify the request and build the byte it carries
	always_comb begin
		known         = 1'b1;
		push_cmd.op   = lcdnib_pkg::OP_INIT;
		push_cmd.code = 8'h00;
		case (req.kind)
			lcdnib_pkg::KIND_INIT: begin
				push_cmd.op = lcdnib_pkg::OP_INIT;
			end
			lcdnib_pkg::KIND_CHAR: begin
				push_cmd.op   = lcdnib_pkg::OP_DATA;
				push_cmd.code = req.char_code;
			end
			lcdnib_pkg::KIND_POS: begin
				// row adds 64, the sum is 7 bits wide
				push_cmd.op   = lcdnib_pkg::OP_ADDR;
				push_cmd.code = {lcdnib_pkg::CMD_DDRAM[7], req.line, req.column};
			end
			default: begin
				// reserved kind: taken and dropped
				known = 1'b0;
			end
		endcase
	end

	assign push = req.valid && req.ready && known;

endmodule

### rtl/lcdnib_queue.sv
`timescale 1ns / 1ps

module lcdnib_queue #(
	parameter int DEPTH = lcdnib_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcdnib_pkg::cmd_t  push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output lcdnib_pkg::cmd_t  pop_cmd
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	lcdnib_pkg::cmd_t  entry_q [DEPTH];
	logic [IDX_W-1:0]  wr_ptr_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_FULL);
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Checks
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("queue read while empty");

endmodule

### rtl/lcdnib_back.sv
`timescale 1ns / 1ps

module lcdnib_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  lcdnib_pkg::cmd_t  cmd,
	output logic              pop,
	lcdnib_xfer_if.source     xfer
);

	logic                            busy_q;
	lcdnib_pkg::cmd_t                cmd_q;
	logic [lcdnib_pkg::STEP_W-1:0]   step_q;
	logic                            out_valid_q;
	lcdnib_pkg::xfer_t               xfer_q;

	lcdnib_pkg::xfer_t               cur;
	lcdnib_pkg::init_entry_t         ie;
	logic                            load;

	// Output slot is free or being emptied this cycle
	assign load = !out_valid_q || xfer.ready;

	// Transfer for the current step
	always_comb begin
		ie               = lcdnib_pkg::init_xfer(step_q);
		cur.nibble       = ie.nibble;
		cur.reg_select   = 1'b0;
		cur.pre_wait_us  = ie.pre;
		cur.post_wait_us = ie.post;
		cur.last         = (step_q == lcdnib_pkg::INIT_LAST);
		if (cmd_q.op != lcdnib_pkg::OP_INIT) begin
			// byte request: high nibble on step 0, low nibble on step 1
			cur.nibble       = step_q[0] ? cmd_q.code[3:0] : cmd_q.code[7:4];
			cur.reg_select   = (cmd_q.op == lcdnib_pkg::OP_DATA);
			cur.pre_wait_us  = lcdnib_pkg::WAIT_NONE;
			cur.post_wait_us = lcdnib_pkg::WAIT_NONE;
			if (step_q[0]) begin
				cur.post_wait_us = (cmd_q.op == lcdnib_pkg::OP_DATA) ?
					lcdnib_pkg::WAIT_DATA : lcdnib_pkg::WAIT_CMD;
			end
			cur.last = step_q[0];
		end
	end

	// Fetch the next request when idle or on the last step of this one
	assign pop = cmd_valid && (!busy_q || (load && cur.last));

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (load && busy_q) begin
				step_q <= step_q + 1'b1;
				if (cur.last) begin
					busy_q <= 1'b0;
				end
			end
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load && busy_q) begin
			xfer_q <= cur;
		end
	end

	assign xfer.valid        = out_valid_q;
	assign xfer.nibble       = xfer_q.nibble;
	assign xfer.reg_select   = xfer_q.reg_select;
	assign xfer.pre_wait_us  = xfer_q.pre_wait_us;
	assign xfer.post_wait_us = xfer_q.post_wait_us;
	assign xfer.last         = xfer_q.last;

	// Checks
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= lcdnib_pkg::INIT_LAST)
		else $error("init step beyond end of run");

	a_byte_two_steps: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cmd_q.op != lcdnib_pkg::OP_INIT |-> step_q <= 4'd1)
		else $error("byte request beyond two transfers");

	a_first_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> busy_q && step_q == '0)
		else $error("fetched request did not start at step zero");

endmodule

### rtl/char_lcd_nibble_sequencer_top.sv
`timescale 1ns / 1ps

// Channel | Role   | Payload
// req     | sink   | kind, char_code, column, line
// xfer    | source | nibble, reg_select, pre_wait_us, post_wait_us, last
//
// An init request emits 14 transfers, a character or position request 2:
// the back output register emits one transfer per cycle unless xfer stalls.
// Queue, fetch and output registers lie between a request and its transfers.
// Reset clears the queue, the sequencer and the output valid at once.
// A stall on xfer holds the output; up to QUEUE_DEPTH requests wait meanwhile.
module char_lcd_nibble_sequencer_top #(
	parameter int QUEUE_DEPTH = lcdnib_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	lcdnib_req_if.sink    req,
	lcdnib_xfer_if.source xfer
);

	logic             push;
	lcdnib_pkg::cmd_t push_cmd;
	logic             full;
	logic             pop;
	logic             pop_valid;
	lcdnib_pkg::cmd_t pop_cmd;

	// Front: accept and classify
	lcdnib_front u_front (
		.req      (req),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Queue between front and back
	lcdnib_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	// Back: transfer sequencer
	lcdnib_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.pop       (pop),
		.xfer      (xfer)
	);

endmodule
